### src/imb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_pkg
// Shared types, constants and coefficient table for the IMU preprocessor.
// ----------------------------------------------------------------------------
package imb_pkg;

    localparam int MEDIAN_TAPS_DEF         = 5;
    localparam int SAMPLE_BITS_DEF         = 16;
    localparam int STATE_FRACTION_BITS_DEF = 24;

    localparam int NCHAN      = 6;
    localparam int NFILT      = 9;
    localparam int STATE_BITS = 48;
    localparam int DELAY_DEPTH = NFILT * 4;
    localparam int DELAY_AW    = $clog2(DELAY_DEPTH);

    // Filter kinds, index the coefficient table
    localparam logic [1:0] KIND_ACC_LP  = 2'd0;
    localparam logic [1:0] KIND_GYRO_HP = 2'd1;
    localparam logic [1:0] KIND_GRAV_LP = 2'd2;

    typedef logic signed [47:0] s48_t;
    typedef logic signed [32:0] coef_t;

    localparam logic signed [47:0] S48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] S48_MIN = -48'sh7FFF_FFFF_FFFF - 48'sd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MWRITE,
        ST_MREAD,
        ST_MSORT,
        ST_FRD,
        ST_FWAIT,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_FWR,
        ST_OUT
    } state_t;

    // Coefficient: kind (accel LP, gyro HP, gravity LP), index 0..9
    function automatic coef_t coef(input logic [1:0] kind, input logic [3:0] idx);
        coef_t r;
        r = '0;
        case (kind)
            KIND_ACC_LP:
                case (idx)
                    4'd0: r = 33'sd100911171;
                    4'd1: r = 33'sd201822342;
                    4'd2: r = 33'sd100911171;
                    4'd3: r = 33'sd0;
                    4'd4: r = 33'sd42483808;
                    4'd5: r = 33'sd1073741824;
                    4'd6: r = 33'sd2147483648;
                    4'd7: r = 33'sd1073741824;
                    4'd8: r = 33'sd0;
                    4'd9: r = 33'sd479385665;
                    default: r = '0;
                endcase
            KIND_GYRO_HP:
                case (idx)
                    4'd0: r = 33'sd1030558322;
                    4'd1: r = -33'sd2061116644;
                    4'd2: r = 33'sd1030558322;
                    4'd3: r = -33'sd2085891916;
                    4'd4: r = 33'sd1013179865;
                    4'd5: r = 33'sd1073741824;
                    4'd6: r = -33'sd2147483648;
                    4'd7: r = 33'sd1073741824;
                    4'd8: r = -33'sd2120929615;
                    4'd9: r = 33'sd1048234861;
                    default: r = '0;
                endcase
            KIND_GRAV_LP:
                case (idx)
                    4'd0: r = 33'sd2309;
                    4'd1: r = 33'sd4618;
                    4'd2: r = 33'sd2309;
                    4'd3: r = -33'sd1996167945;
                    4'd4: r = 33'sd928598664;
                    4'd5: r = 33'sd1073741824;
                    4'd6: r = 33'sd2147483648;
                    4'd7: r = 33'sd1073741824;
                    4'd8: r = -33'sd2078457983;
                    4'd9: r = 33'sd1011143159;
                    default: r = '0;
                endcase
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic s48_t sat48(input logic signed [49:0] x);
        s48_t r;
        if (x > 50'(S48_MAX))
            r = S48_MAX;
        else if (x < 50'(S48_MIN))
            r = S48_MIN;
        else
            r = x[47:0];
        return r;
    endfunction

endpackage

### src/imb_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_stream_if
// Valid/ready channel carrying six signed samples.
// ----------------------------------------------------------------------------
interface imb_stream_if #(
    parameter int SAMPLE_BITS = imb_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] f0;
    logic signed [SAMPLE_BITS-1:0] f1;
    logic signed [SAMPLE_BITS-1:0] f2;
    logic signed [SAMPLE_BITS-1:0] f3;
    logic signed [SAMPLE_BITS-1:0] f4;
    logic signed [SAMPLE_BITS-1:0] f5;

    modport source (output valid, f0, f1, f2, f3, f4, f5, input ready);
    modport sink   (input valid, f0, f1, f2, f3, f4, f5, output ready);
endinterface

### src/imb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module imb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 36
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write or read one entry per cycle
    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

### src/imb_mulq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_mulq
// Rounded Q2.30 product of a 48-bit signal, two 24x33 partial products.
// ----------------------------------------------------------------------------
module imb_mulq (
    input  logic                clk,
    input  logic                start,
    input  imb_pkg::s48_t       v,
    input  imb_pkg::coef_t      c,
    output logic signed [49:0]  prod
);
    logic signed [24:0] lo_reg;
    logic signed [23:0] hi_reg;
    imb_pkg::coef_t     c_reg;
    logic signed [57:0] plo_reg;
    logic signed [56:0] phi_reg;
    logic               ph_reg;
    logic signed [81:0] full;

    // Split operand, then multiply the low half, then the high half
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_reg <= $signed({1'b0, v[23:0]});
            hi_reg <= v[47:24];
            c_reg  <= c;
            ph_reg <= 1'b0;
        end
        else if (!ph_reg)
        begin
            plo_reg <= lo_reg * c_reg;
            ph_reg  <= 1'b1;
        end
        else
        begin
            phi_reg <= hi_reg * c_reg;
        end
    end

    assign full = ($signed({phi_reg, 24'd0}) + 82'(plo_reg)) + 82'sd536870912;
    assign prod = full[79:30];
endmodule

### src/imb_median.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imb_median
// Rank-based median of one channel window held in a shift register.
// ----------------------------------------------------------------------------
module imb_median #(
    parameter int MEDIAN_TAPS = imb_pkg::MEDIAN_TAPS_DEF,
    parameter int SAMPLE_BITS = imb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [SAMPLE_BITS-1:0]        din,
    input  logic [$clog2(MEDIAN_TAPS)-1:0] idx,
    input  logic                          rd,
    input  logic                          capture,
    output logic signed [SAMPLE_BITS-1:0] med
);
    logic signed [SAMPLE_BITS-1:0] w_reg [MEDIAN_TAPS];
    logic signed [SAMPLE_BITS-1:0] cand_reg;
    logic signed [SAMPLE_BITS-1:0] med_reg;
    logic [$clog2(MEDIAN_TAPS+1)-1:0] lt, le;

    // Window shift line: newest in slot 0 (order is irrelevant to median)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < MEDIAN_TAPS; i++) w_reg[i] <= '0;
        else if (load)
        begin
            w_reg[0] <= $signed(din);
            for (int i = 1; i < MEDIAN_TAPS; i++) w_reg[i] <= w_reg[i-1];
        end
    end

    // Count elements below and at the candidate
    always_comb
    begin
        lt = '0;
        le = '0;
        for (int i = 0; i < MEDIAN_TAPS; i++)
        begin
            lt = lt + (w_reg[i] < cand_reg ? 1'b1 : 1'b0);
            le = le + (w_reg[i] <= cand_reg ? 1'b1 : 1'b0);
        end
    end

    // Walk candidates, keep the one whose rank covers the middle
    always_ff @(posedge clk)
    begin
        if (rd)
            cand_reg <= w_reg[idx];
        if (capture && lt <= ($clog2(MEDIAN_TAPS+1))'(MEDIAN_TAPS / 2)
                    && le > ($clog2(MEDIAN_TAPS+1))'(MEDIAN_TAPS / 2))
            med_reg <= cand_reg;
    end

    assign med = med_reg;
endmodule

### src/imu_median_biquad_preprocessor_core.sv
`timescale 1ns / 1ps
// Per input transfer the median pass reads and ranks each window tap, then 18
// biquad sections run, each 2 reads, 1 wait, five products on the shared
// multiplier and 2 writes to the filter-state RAM. No new sample is taken
// until the last one is loaded into the output register; a held result stalls
// the input only once the next one is also done. After reset a pass clears the
// filter-state RAM, during which no input is taken. Windows and control clear at once.
// ----------------------------------------------------------------------------
// imu_median_biquad_preprocessor_core
// Median windows, accel lowpass minus gravity, gyro highpass.
// ----------------------------------------------------------------------------
module imu_median_biquad_preprocessor_core #(
    parameter int MEDIAN_TAPS         = imb_pkg::MEDIAN_TAPS_DEF,
    parameter int SAMPLE_BITS         = imb_pkg::SAMPLE_BITS_DEF,
    parameter int STATE_FRACTION_BITS = imb_pkg::STATE_FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    imb_stream_if.sink   in_s,
    imb_stream_if.source out_s
);
    localparam int TW = $clog2(MEDIAN_TAPS);
    localparam int AW = imb_pkg::DELAY_AW;

    imb_pkg::state_t state_reg, state_next;
    logic [TW-1:0]   tap_reg;
    logic [3:0]      filt_reg;
    logic            sec_reg;
    logic [2:0]      mstep_reg;
    logic [1:0]      sub_reg;
    logic [AW:0]     clr_reg;
    logic            clr_done_reg;
    logic            out_valid_reg;
    logic [SAMPLE_BITS-1:0] res_reg [imb_pkg::NCHAN];
    logic [SAMPLE_BITS-1:0] out_reg [imb_pkg::NCHAN];
    logic [SAMPLE_BITS-1:0] din [imb_pkg::NCHAN];
    logic signed [SAMPLE_BITS-1:0] med [imb_pkg::NCHAN];

    imb_pkg::s48_t x_reg, y_reg, w1_reg, w2_reg, lp_reg [3];
    logic signed [49:0] acc_reg;
    logic [47:0]   rdata;
    logic          we;
    logic [AW-1:0] addr;
    logic [47:0]   wdata;
    logic          mstart;
    imb_pkg::s48_t mv;
    imb_pkg::coef_t mc;
    logic signed [49:0] prod;
    logic [1:0]    kind;
    logic [3:0]    cbase;
    logic [1:0]    fch;
    logic [2:0]    mch;
    logic [SAMPLE_BITS-1:0] outv;
    logic signed [49:0] tmp;
    logic signed [49:0] rnd;
    logic signed [63:0] xin;
    imb_pkg::s48_t xsat;
    logic          out_load;

    assign din[0] = in_s.f0;
    assign din[1] = in_s.f1;
    assign din[2] = in_s.f2;
    assign din[3] = in_s.f3;
    assign din[4] = in_s.f4;
    assign din[5] = in_s.f5;

    for (genvar g = 0; g < imb_pkg::NCHAN; g++)
    begin : g_med
        imb_median #(.MEDIAN_TAPS(MEDIAN_TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_med (
            .clk(clk), .rst_n(rst_n),
            .load(in_s.valid && in_s.ready), .din(din[g]),
            .idx(tap_reg), .rd(state_reg == imb_pkg::ST_MREAD),
            .capture(state_reg == imb_pkg::ST_MSORT), .med(med[g])
        );
    end

    // Filter order: 0..2 accel LP, 3..5 gyro HP, 6..8 gravity LP
    always_comb
    begin
        kind = imb_pkg::KIND_ACC_LP;
        fch  = 2'd0;
        if (filt_reg < 4'd3)
        begin
            kind = imb_pkg::KIND_ACC_LP;
            fch  = filt_reg[1:0];
        end
        else if (filt_reg < 4'd6)
        begin
            kind = imb_pkg::KIND_GYRO_HP;
            fch  = 2'(filt_reg - 4'd3);
        end
        else
        begin
            kind = imb_pkg::KIND_GRAV_LP;
            fch  = 2'(filt_reg - 4'd6);
        end
    end

    // Sample channel of the current filter: gyro filters take channels 3..5
    assign mch = (kind == imb_pkg::KIND_GYRO_HP) ? 3'({1'b0, fch}) + 3'd3 : 3'({1'b0, fch});

    assign cbase = sec_reg ? 4'd5 : 4'd0;
    assign addr = clr_done_reg ? AW'({filt_reg, sec_reg, sub_reg[0]}) : clr_reg[AW-1:0];
    assign we   = !clr_done_reg || (state_reg == imb_pkg::ST_FWR);
    assign wdata = !clr_done_reg ? 48'd0 : (sub_reg[0] ? w2_reg : w1_reg);

    imb_ram #(.WIDTH(48), .DEPTH(imb_pkg::DELAY_DEPTH)) u_state (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // Product operand select per step: b0*x, b1*x, a1*y, b2*x, a2*y
    always_comb
    begin
        mv = x_reg;
        mc = imb_pkg::coef(kind, cbase);
        case (mstep_reg)
            3'd0: begin mv = x_reg; mc = imb_pkg::coef(kind, cbase); end
            3'd1: begin mv = x_reg; mc = imb_pkg::coef(kind, cbase + 4'd1); end
            3'd2: begin mv = y_reg; mc = imb_pkg::coef(kind, cbase + 4'd3); end
            3'd3: begin mv = x_reg; mc = imb_pkg::coef(kind, cbase + 4'd2); end
            3'd4: begin mv = y_reg; mc = imb_pkg::coef(kind, cbase + 4'd4); end
            default: begin mv = x_reg; mc = imb_pkg::coef(kind, cbase); end
        endcase
    end

    imb_mulq u_mul (.clk(clk), .start(mstart), .v(mv), .c(mc), .prod(prod));

    assign mstart = (state_reg == imb_pkg::ST_M0) && sub_reg == 2'd0;

    // Load the output register once it is free or being taken
    assign out_load = (state_reg == imb_pkg::ST_OUT) && (!out_valid_reg || out_s.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            imb_pkg::ST_IDLE:   if (in_s.valid && in_s.ready) state_next = imb_pkg::ST_MREAD;
            imb_pkg::ST_MREAD:  state_next = imb_pkg::ST_MSORT;
            imb_pkg::ST_MSORT:
                state_next = (32'(tap_reg) == MEDIAN_TAPS - 1) ? imb_pkg::ST_FRD
                                                               : imb_pkg::ST_MREAD;
            imb_pkg::ST_FRD:    state_next = (sub_reg[0]) ? imb_pkg::ST_FWAIT : imb_pkg::ST_FRD;
            imb_pkg::ST_FWAIT:  state_next = imb_pkg::ST_M0;
            imb_pkg::ST_M0:     if (sub_reg == 2'd3) state_next = imb_pkg::ST_M1;
            imb_pkg::ST_M1:     state_next = (mstep_reg == 3'd4) ? imb_pkg::ST_FWR : imb_pkg::ST_M0;
            imb_pkg::ST_FWR:
                if (sub_reg[0])
                    state_next = (sec_reg && filt_reg == 4'd8) ? imb_pkg::ST_OUT
                                                               : imb_pkg::ST_FRD;
            imb_pkg::ST_OUT:    if (out_load) state_next = imb_pkg::ST_IDLE;
            default:            state_next = imb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= imb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Round the state value back to sample counts with saturation
    function automatic logic [SAMPLE_BITS-1:0] to_field(input imb_pkg::s48_t v);
        logic signed [49:0] r;
        logic signed [49:0] hi;
        r  = (50'(v) + (50'sd1 <<< (STATE_FRACTION_BITS - 1))) >>> STATE_FRACTION_BITS;
        hi = (50'sd1 <<< (SAMPLE_BITS - 1)) - 50'sd1;
        if (r > hi) r = hi;
        if (r < -hi - 50'sd1) r = -hi - 50'sd1;
        return r[SAMPLE_BITS-1:0];
    endfunction

    // Sequence counters and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0; filt_reg <= '0; sec_reg <= 1'b0;
            mstep_reg <= '0; sub_reg <= '0; clr_reg <= '0; clr_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!clr_done_reg)
            begin
                clr_reg <= clr_reg + 1'b1;
                if (32'(clr_reg) == imb_pkg::DELAY_DEPTH - 1) clr_done_reg <= 1'b1;
            end
            if (out_s.valid && out_s.ready) out_valid_reg <= 1'b0;
            if (out_load) out_valid_reg <= 1'b1;
            case (state_reg)
                imb_pkg::ST_IDLE: begin tap_reg <= '0; filt_reg <= '0; sec_reg <= 1'b0;
                                        sub_reg <= '0; end
                imb_pkg::ST_MSORT:
                    if (32'(tap_reg) != MEDIAN_TAPS - 1) tap_reg <= tap_reg + 1'b1;
                imb_pkg::ST_FRD: sub_reg <= sub_reg[0] ? 2'd0 : 2'd1;
                imb_pkg::ST_FWAIT: mstep_reg <= '0;
                imb_pkg::ST_M0: sub_reg <= sub_reg + 2'd1;
                imb_pkg::ST_M1:
                begin
                    sub_reg <= '0;
                    mstep_reg <= mstep_reg + 3'd1;
                end
                imb_pkg::ST_FWR:
                begin
                    sub_reg <= sub_reg[0] ? 2'd0 : 2'd1;
                    if (sub_reg[0])
                    begin
                        sec_reg <= !sec_reg;
                        if (sec_reg && filt_reg != 4'd8) filt_reg <= filt_reg + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Section datapath: delay-word pickup, products, results
    always_ff @(posedge clk)
    begin
        if (state_reg == imb_pkg::ST_FRD && sub_reg[0])
            w1_reg <= rdata;
        if (state_reg == imb_pkg::ST_FWAIT)
            w2_reg <= rdata;
        if (state_reg == imb_pkg::ST_FRD && !sub_reg[0] && !sec_reg)
            x_reg <= (kind == imb_pkg::KIND_GRAV_LP) ? lp_reg[fch] : xsat;
        if (state_reg == imb_pkg::ST_M1)
        begin
            case (mstep_reg)
                3'd0: y_reg <= imb_pkg::sat48(prod + 50'(w1_reg));
                3'd1: acc_reg <= prod + 50'(w2_reg);
                3'd2: w1_reg <= imb_pkg::sat48(acc_reg - prod);
                3'd3: acc_reg <= prod;
                3'd4: w2_reg <= imb_pkg::sat48(acc_reg - prod);
                default: ;
            endcase
        end
        if (state_reg == imb_pkg::ST_FWR && sub_reg[0])
        begin
            if (!sec_reg)
                x_reg <= y_reg;
            else
            begin
                if (kind == imb_pkg::KIND_ACC_LP) lp_reg[fch] <= y_reg;
                else res_reg[mch] <= outv;
            end
        end
        if (out_load)
            for (int i = 0; i < imb_pkg::NCHAN; i++) out_reg[i] <= res_reg[i];
    end

    assign xin  = 64'(med[mch]) <<< STATE_FRACTION_BITS;
    assign xsat = (xin > 64'(imb_pkg::S48_MAX)) ? imb_pkg::S48_MAX :
                  (xin < 64'(imb_pkg::S48_MIN)) ? imb_pkg::S48_MIN : xin[47:0];
    assign tmp  = 50'(lp_reg[fch]) - 50'(y_reg);
    assign rnd  = (kind == imb_pkg::KIND_GRAV_LP) ? 50'(imb_pkg::sat48(tmp)) : 50'(y_reg);
    assign outv = to_field(rnd[47:0]);

    assign in_s.ready = clr_done_reg && state_reg == imb_pkg::ST_IDLE;
    assign out_s.valid = out_valid_reg;
    assign out_s.f0 = out_reg[0];
    assign out_s.f1 = out_reg[1];
    assign out_s.f2 = out_reg[2];
    assign out_s.f3 = out_reg[3];
    assign out_s.f4 = out_reg[4];
    assign out_s.f5 = out_reg[5];

`ifndef SYNTH
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != imb_pkg::ST_IDLE) |-> !in_s.ready) else $error("ready while busy");
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        !clr_done_reg |-> !in_s.ready) else $error("input during clear");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_s.valid && !out_s.ready) |=> out_s.valid) else $error("result dropped");
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_s.valid && in_s.ready) |=> state_reg == imb_pkg::ST_MREAD)
        else $error("sequence not started");
`endif
endmodule
